// ===== hdl/egcd_pkg.sv =====
// Package for the extended Euclidean block: field widths, transaction payload
// structs and the status struct of the shared division unit.
// No dependencies.
package egcd_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int IN_W            = 31;
    localparam int GCD_W           = 31;
    localparam int COEF_W          = 32;

    typedef struct packed {
        logic [IN_W-1:0] first_value;
        logic [IN_W-1:0] second_value;
    } t_in_item;

    typedef struct packed {
        logic [GCD_W-1:0]         gcd_value;
        logic signed [COEF_W-1:0] coef_larger;
        logic signed [COEF_W-1:0] coef_smaller;
        logic                     first_was_larger;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hdl/extended_gcd_bezout.sv =====
// Top level of the extended Euclidean block: operand ordering, step sequencer,
// coefficient registers and result register. Uses egcd_pkg and egcd_div_unit.
//
// Channel | Direction | Handshake                | Payload
// input   | in        | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
// output  | out       | o_out_valid / i_out_ready| o_out_data (t_out_item)
//
// Each remainder step is one pass through the bit-serial divider.
// Only one item is in flight: o_in_ready is high while the sequencer is idle.
// The result register lets a new transaction in while a result waits; a finished
// item holds in place until that register is free. Reset is synchronous, active low.
module extended_gcd_bezout
    import egcd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [VALUE_WIDTH-1:0] r_r0;
    logic [VALUE_WIDTH-1:0] r_r1;
    logic [COEF_W-1:0]      r_s0;
    logic [COEF_W-1:0]      r_s1;
    logic [COEF_W-1:0]      r_t0;
    logic [COEF_W-1:0]      r_t1;
    logic                   r_first_big;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [VALUE_WIDTH-1:0] x_val;
    logic [VALUE_WIDTH-1:0] y_val;
    logic                   x_big;
    logic                   in_accept;
    logic                   div_start;
    logic                   out_load;
    t_div_stat              div_stat;
    logic [VALUE_WIDTH-1:0] div_rem;
    logic [COEF_W-1:0]      div_qs;
    logic [COEF_W-1:0]      div_qt;

    assign x_val     = VALUE_WIDTH'(i_in_data.first_value);
    assign y_val     = VALUE_WIDTH'(i_in_data.second_value);
    assign x_big     = (x_val > y_val);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept = i_in_valid && o_in_ready;
    assign div_start = (r_state == S_CHECK) && (r_r1 != '0);
    assign out_load  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    egcd_div_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_r0),
        .i_divisor  (r_r1),
        .i_s1       (r_s1),
        .i_t1       (r_t1),
        .o_stat     (div_stat),
        .o_rem      (div_rem),
        .o_qs       (div_qs),
        .o_qt       (div_qt)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = (r_r1 == '0) ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) n_state = S_CHECK;
            end
            S_FINISH: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_first_big <= x_big;
            r_r0        <= x_big ? x_val : y_val;
            r_r1        <= x_big ? y_val : x_val;
            r_s0        <= COEF_W'(1);
            r_s1        <= '0;
            r_t0        <= '0;
            r_t1        <= COEF_W'(1);
        end else if ((r_state == S_DIV) && div_stat.done) begin
            r_r0 <= r_r1;
            r_r1 <= div_rem;
            r_s0 <= r_s1;
            r_s1 <= r_s0 - div_qs;
            r_t0 <= r_t1;
            r_t1 <= r_t0 - div_qt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.gcd_value        <= GCD_W'(r_r0);
            r_out.coef_larger      <= r_s0;
            r_out.coef_smaller     <= r_t0;
            r_out.first_was_larger <= r_first_big;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The divider may only run while the sequencer waits on it.
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_DIV))
        else $error("divider busy outside the division state");

    // A completion pulse must come after a division was started for this step.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV) && $past(div_stat.busy))
        else $error("divider completion without a running division");

    // The remainder sequence never grows: the smaller operand never exceeds the larger.
    a_order_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_r1 <= r_r0))
        else $error("remainder sequence out of order");

    // An accepted transaction starts the step loop on the next cycle.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_CHECK))
        else $error("accepted transaction did not start the sequencer");

endmodule

// ===== hdl/egcd_div_unit.sv =====
// Shared restoring divider, one quotient bit per cycle. Alongside the remainder
// it accumulates the quotient times both Bezout coefficients, modulo 2^COEF_W.
// Depends on egcd_pkg.
module egcd_div_unit
    import egcd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    input  logic [COEF_W-1:0]      i_s1,
    input  logic [COEF_W-1:0]      i_t1,
    output t_div_stat              o_stat,
    output logic [VALUE_WIDTH-1:0] o_rem,
    output logic [COEF_W-1:0]      o_qs,
    output logic [COEF_W-1:0]      o_qt
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [VALUE_WIDTH-1:0] r_dsr;
    logic [COEF_W-1:0]      r_s1;
    logic [COEF_W-1:0]      r_t1;
    logic [COEF_W-1:0]      r_qs;
    logic [COEF_W-1:0]      r_qt;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   q_bit;
    logic [VALUE_WIDTH-1:0] n_rem;

    assign trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign q_bit = (trial >= {1'b0, r_dsr});
    // The partial remainder stays below the divisor, so it fits the operand width.
    assign n_rem = q_bit ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_s1  <= i_s1;
            r_t1  <= i_t1;
            r_qs  <= '0;
            r_qt  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
            // Quotient bits arrive most significant first: shift and add.
            r_qs  <= (r_qs << 1) + (q_bit ? r_s1 : '0);
            r_qt  <= (r_qt << 1) + (q_bit ? r_t1 : '0);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;
    assign o_qs        = r_qs;
    assign o_qt        = r_qt;

endmodule

// ===== bench/egcd_checker.sv =====
// Checker for the extended Euclidean block: watches both channels, predicts each
// result from the accepted operands and compares it field by field.
// Depends on egcd_pkg for the transaction payload types.
module egcd_checker
    import egcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_pending,
    output int        o_mismatches,
    output int        o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out_item bezout_due[$];

    // Remainder sequence with the coefficients kept modulo 2^64 and cut to the
    // output width at the end.
    function automatic t_out_item bezout_of(input t_in_item item);
        logic [63:0] a, b, r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
        logic        first_big;
        t_out_item   res;
        a = 64'(item.first_value);
        b = 64'(item.second_value);
        first_big = a > b;
        r0 = first_big ? a : b;
        r1 = first_big ? b : a;
        s0 = 64'd1;
        s1 = 64'd0;
        t0 = 64'd0;
        t1 = 64'd1;
        while (r1 != 64'd0) begin
            q  = r0 / r1;
            rn = r0 - q * r1;
            sn = s0 - q * s1;
            tn = t0 - q * t1;
            r0 = r1;
            r1 = rn;
            s0 = s1;
            s1 = sn;
            t0 = t1;
            t1 = tn;
        end
        res.gcd_value        = r0[GCD_W-1:0];
        res.coef_larger      = s0[COEF_W-1:0];
        res.coef_smaller     = t0[COEF_W-1:0];
        res.first_was_larger = first_big;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            o_pending    <= 0;
            o_mismatches <= 0;
            o_results    <= 0;
        end else begin
            // A result taken in the same cycle as new operands belongs to the
            // earlier transaction, so the queue is popped before it is pushed.
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (bezout_due.size() == 0) begin
                    $display("%0t: unexpected result gcd=%0d coef_larger=%0d coef_smaller=%0d",
                             $time, i_out_data.gcd_value, i_out_data.coef_larger,
                             i_out_data.coef_smaller);
                    errs++;
                end else begin
                    due = bezout_due.pop_front();
                    if (i_out_data.gcd_value !== due.gcd_value) begin
                        $display("%0t: gcd_value expected %0d, actual %0d",
                                 $time, due.gcd_value, i_out_data.gcd_value);
                        errs++;
                    end
                    if (i_out_data.coef_larger !== due.coef_larger) begin
                        $display("%0t: coef_larger expected %0d, actual %0d",
                                 $time, due.coef_larger, i_out_data.coef_larger);
                        errs++;
                    end
                    if (i_out_data.coef_smaller !== due.coef_smaller) begin
                        $display("%0t: coef_smaller expected %0d, actual %0d",
                                 $time, due.coef_smaller, i_out_data.coef_smaller);
                        errs++;
                    end
                    if (i_out_data.first_was_larger !== due.first_was_larger) begin
                        $display("%0t: first_was_larger expected %0b, actual %0b",
                                 $time, due.first_was_larger, i_out_data.first_was_larger);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                bezout_due = {bezout_due, bezout_of(i_in_data)};
            end
            o_mismatches <= o_mismatches + errs;
            o_pending    <= bezout_due.size();
        end
    end

endmodule

// ===== bench/extended_gcd_bezout_test.sv =====
// Testbench top for extended_gcd_bezout: clock, reset, operand stimulus, result
// back-pressure, watchdog and verdict. Depends on egcd_pkg, the block and egcd_checker.
module extended_gcd_bezout_test
    import egcd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 8000;
    localparam int TAIL_CYCLES = 1600;
    localparam int RANDOM_PAIRS = 380;
    localparam logic [IN_W-1:0] TOP = {IN_W{1'b1}};
    localparam logic [IN_W-1:0] FIB45 = 31'd1134903170;
    localparam logic [IN_W-1:0] FIB46 = 31'd1836311903;

    logic      i_clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    int pending;
    int mismatches;
    int results;
    int pairs_sent;
    int directed_sent;
    int results_taken;
    int idle_cycles;
    logic calm;

    extended_gcd_bezout dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    egcd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_pair(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data.first_value  = a;
        in_data.second_value = b;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        pairs_sent++;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly full-width operands, with small, common-factor, lopsided, equal and
    // zero pairs mixed in.
    function automatic t_in_item draw_pair();
        t_in_item p;
        int       pick;
        int       k;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            p.first_value  = IN_W'($urandom());
            p.second_value = IN_W'($urandom());
        end else if (pick < 75) begin
            p.first_value  = IN_W'($urandom_range(0, 999));
            p.second_value = IN_W'($urandom_range(0, 999));
        end else if (pick < 85) begin
            k = $urandom_range(1, 65535);
            p.first_value  = IN_W'($urandom_range(0, 32767) * k);
            p.second_value = IN_W'($urandom_range(0, 32767) * k);
        end else if (pick < 92) begin
            p.first_value  = IN_W'($urandom());
            p.second_value = IN_W'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1) begin
                p = {p.second_value, p.first_value};
            end
        end else if (pick < 96) begin
            p.first_value  = IN_W'($urandom());
            p.second_value = p.first_value;
        end else begin
            p.first_value  = ($urandom_range(0, 1) == 1) ? IN_W'($urandom()) : '0;
            p.second_value = '0;
            if ($urandom_range(0, 1) == 1) begin
                p = {p.second_value, p.first_value};
            end
        end
        return p;
    endfunction

    // The receiver stalls for a drawn number of cycles before each result,
    // except in the third of every four runs of 25 results.
    initial begin
        int stall;
        out_ready = 1'b0;
        results_taken = 0;
        forever begin
            stall = (((results_taken / 25) % 4) == 2) ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready = 1'b1;
            @(posedge i_clk);
            while (!(out_valid && out_ready)) @(posedge i_clk);
            results_taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_in_item p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        calm = 1'b0;
        pairs_sent = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        send_pair('0, '0);
        send_pair(31'd9, '0);
        send_pair('0, 31'd9);
        send_pair(31'd7, 31'd7);
        send_pair(TOP, TOP);
        send_pair(TOP, '0);
        send_pair('0, TOP);
        send_pair(TOP, 31'd1);
        send_pair(31'd1, TOP);
        send_pair(TOP, TOP - 31'd1);
        send_pair(TOP - 31'd1, TOP);
        // Consecutive Fibonacci numbers take the longest remainder sequence.
        send_pair(FIB46, FIB45);
        send_pair(FIB45, FIB46);
        send_pair(31'd240, 31'd46);
        send_pair(31'd46, 31'd240);
        send_pair(31'd1, 31'd1);
        send_pair(31'd1, '0);
        send_pair(31'h55555555, 31'h2AAAAAAA);
        send_pair(31'h2AAAAAAA, 31'h55555555);
        send_pair(31'h40000000, 31'h20000000);
        send_pair(31'd12, 31'd18);
        directed_sent = pairs_sent;

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            calm = (((n / 40) % 4) == 3);
            if (n == 130 || n == 260) begin
                wait_drained();
            end
            p = draw_pair();
            send_pair(p.first_value, p.second_value);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d operand pairs (%0d directed), %0d results compared.",
                 pairs_sent, directed_sent, results);
        $display("Zero, equal, full-scale, Fibonacci and common-factor pairs under random gaps.");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/egcd_pkg.sv
hdl/egcd_div_unit.sv
hdl/extended_gcd_bezout.sv
bench/egcd_checker.sv
bench/extended_gcd_bezout_test.sv
